@@ src/assert_macros.svh @@
// Concurrent assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CDQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cdq: assertion failed");

// Check that a condition is followed by another in the next cycle.
`define CDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdq: sequencing check failed");

`endif

@@ src/cdq_pkg.sv @@
`default_nettype none

package cdq_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int VAL_W = 32;
    localparam int CMD_W = 3;
    localparam int STS_W = 2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic signed [VAL_W-1:0] t_value;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SHOW       = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        RS_OK    = 2'd0,
        RS_EMPTY = 2'd1,
        RS_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SHOW
    } t_state;

    typedef struct packed {
        logic    latch_req;
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    clear;
        logic    show_start;
        logic    show_read;
        logic    out_load;
        logic    out_from_read;
        t_status out_status;
        logic    out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             show_more;
        logic             rd_last;
    } t_dp_stat;

    function automatic t_idx ring_slot(input t_idx front, input t_cnt offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic t_idx ring_dec(input t_idx front);
        t_idx res;
        if (front == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = front - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/cdq_if.sv @@
`default_nettype none

interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::CMD_W-1:0]           command;
    logic signed [cdq_pkg::VAL_W-1:0]    value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [cdq_pkg::STS_W-1:0]           status;
    logic signed [cdq_pkg::VAL_W-1:0]    item_value;
    logic                                last;

    modport source (output valid, output status, output item_value, output last, input ready);
    modport sink (input valid, input status, input item_value, input last, output ready);
endinterface

`default_nettype wire

@@ src/cdq_ctrl.sv @@
`default_nettype none

module cdq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    input  wire cdq_pkg::t_dp_stat i_stat,
    output cdq_pkg::t_dp_cmd       o_cmd
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            r_rd_vld;
    logic            n_rd_vld;
    logic            w_out_free;
    logic            w_load;
    logic            w_issue;

    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_rd_vld           = r_rd_vld;
        o_req_ready        = 1'b0;
        w_load             = 1'b0;
        w_issue            = 1'b0;
        o_cmd              = '0;
        o_cmd.out_status   = cdq_pkg::RS_OK;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_state         = cdq_pkg::S_EXEC;
                end
            end
            cdq_pkg::S_EXEC: begin
                unique case (i_stat.cmd)
                    cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
                        if (w_out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = i_stat.full ? cdq_pkg::RS_FULL
                                                           : cdq_pkg::RS_OK;
                            o_cmd.push_front = !i_stat.full
                                && (i_stat.cmd == cdq_pkg::CMD_PUSH_FRONT);
                            o_cmd.push_back  = !i_stat.full
                                && (i_stat.cmd == cdq_pkg::CMD_PUSH_BACK);
                            n_state          = cdq_pkg::S_IDLE;
                        end
                    end
                    cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
                        if (!i_stat.empty) begin
                            o_cmd.pop_front = (i_stat.cmd == cdq_pkg::CMD_POP_FRONT);
                            o_cmd.pop_back  = (i_stat.cmd == cdq_pkg::CMD_POP_BACK);
                            n_state         = cdq_pkg::S_POP;
                        end else if (w_out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = cdq_pkg::RS_EMPTY;
                            n_state          = cdq_pkg::S_IDLE;
                        end
                    end
                    cdq_pkg::CMD_SHOW: begin
                        if (!i_stat.empty) begin
                            o_cmd.show_start = 1'b1;
                            n_state          = cdq_pkg::S_SHOW;
                        end else if (w_out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = cdq_pkg::RS_EMPTY;
                            n_state          = cdq_pkg::S_IDLE;
                        end
                    end
                    cdq_pkg::CMD_CLEAR: begin
                        if (w_out_free) begin
                            o_cmd.clear    = 1'b1;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            n_state        = cdq_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = cdq_pkg::S_IDLE;
                    end
                endcase
            end
            cdq_pkg::S_POP: begin
                if (w_out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_from_read = 1'b1;
                    o_cmd.out_last      = 1'b1;
                    n_state             = cdq_pkg::S_IDLE;
                end
            end
            cdq_pkg::S_SHOW: begin
                w_load  = r_rd_vld && w_out_free;
                w_issue = i_stat.show_more && (!r_rd_vld || w_out_free);
                o_cmd.show_read     = w_issue;
                o_cmd.out_load      = w_load;
                o_cmd.out_from_read = w_load;
                o_cmd.out_last      = w_load && i_stat.rd_last;
                if (w_issue) begin
                    n_rd_vld = 1'b1;
                end else if (w_load) begin
                    n_rd_vld = 1'b0;
                end
                if (w_load && i_stat.rd_last) begin
                    n_state = cdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_rsp_ready ? 1'b0 : r_out_valid);
    end

endmodule

`default_nettype wire

@@ src/cdq_dp.sv @@
`default_nettype none

module cdq_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cdq_pkg::t_dp_cmd              i_cmd,
    input  wire logic [cdq_pkg::CMD_W-1:0]     i_command,
    input  wire cdq_pkg::t_value               i_value,
    output cdq_pkg::t_dp_stat                  o_stat,
    output logic [cdq_pkg::STS_W-1:0]          o_status,
    output cdq_pkg::t_value                    o_item_value,
    output logic                               o_last
);

    cdq_pkg::t_value             r_mem [cdq_pkg::DEPTH];
    cdq_pkg::t_idx               r_front;
    cdq_pkg::t_cnt               r_count;
    cdq_pkg::t_cnt               r_show_idx;
    logic [cdq_pkg::CMD_W-1:0]   r_cmd;
    cdq_pkg::t_value             r_val;
    cdq_pkg::t_value             r_rd_data;
    logic                        r_rd_last;
    cdq_pkg::t_status            r_status;
    cdq_pkg::t_value             r_item;
    logic                        r_last;
    cdq_pkg::t_idx               w_front_dec;
    cdq_pkg::t_idx               w_wr_addr;
    cdq_pkg::t_idx               w_rd_addr;
    logic                        w_wr_en;
    logic                        w_rd_en;

    assign w_front_dec = cdq_pkg::ring_dec(r_front);
    assign w_wr_en     = i_cmd.push_front || i_cmd.push_back;
    assign w_wr_addr   = i_cmd.push_front ? w_front_dec
                                          : cdq_pkg::ring_slot(r_front, r_count);
    assign w_rd_en     = i_cmd.pop_front || i_cmd.pop_back || i_cmd.show_read;

    always_comb begin
        priority if (i_cmd.pop_front) begin
            w_rd_addr = r_front;
        end else if (i_cmd.pop_back) begin
            w_rd_addr = cdq_pkg::ring_slot(r_front, r_count - cdq_pkg::CNT_W'(1));
        end else begin
            w_rd_addr = cdq_pkg::ring_slot(r_front, r_show_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_val;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_show_idx <= '0;
        end else begin
            priority if (i_cmd.clear) begin
                r_front <= '0;
                r_count <= '0;
            end else if (i_cmd.push_front) begin
                r_front <= w_front_dec;
                r_count <= r_count + cdq_pkg::CNT_W'(1);
            end else if (i_cmd.push_back) begin
                r_count <= r_count + cdq_pkg::CNT_W'(1);
            end else if (i_cmd.pop_front) begin
                r_front <= cdq_pkg::ring_slot(r_front, cdq_pkg::CNT_W'(1));
                r_count <= r_count - cdq_pkg::CNT_W'(1);
            end else if (i_cmd.pop_back) begin
                r_count <= r_count - cdq_pkg::CNT_W'(1);
            end else begin
                r_front <= r_front;
                r_count <= r_count;
            end
            priority if (i_cmd.show_start) begin
                r_show_idx <= '0;
            end else if (i_cmd.show_read) begin
                r_show_idx <= r_show_idx + cdq_pkg::CNT_W'(1);
            end else begin
                r_show_idx <= r_show_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (i_cmd.show_read) begin
            r_rd_last <= (r_show_idx + cdq_pkg::CNT_W'(1)) == r_count;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_item   <= i_cmd.out_from_read ? r_rd_data : '0;
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.full      = (r_count == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.show_more = (r_show_idx != r_count);
    assign o_stat.rd_last   = r_rd_last;
    assign o_status         = r_status;
    assign o_item_value     = r_item;
    assign o_last           = r_last;

endmodule

`default_nettype wire

@@ src/circular_deque_engine.sv @@
// Double-ended queue of signed 32-bit values in a 64-entry ring memory.
// Request channel i_req: command (push front/back, pop front/back, show,
// clear) and value. Response channel o_rsp: status, item_value, last.
// One request is worked at a time; i_req.ready is high only while idle.
// From acceptance, a response passes these states and registers before it
// can be taken: push, clear, empty pop, empty show: EXEC, output register;
//   pop: EXEC, memory read register, POP, output register; show: EXEC,
//   SHOW reads, then read and output registers, then one entry per cycle
//   while the receiver keeps taking them. Unused command codes give no response.
// The single memory port that reads one entry per cycle sets the show rate.
// Responses wait in an output register, so a stalled receiver only holds
// the current response; a show stream pauses and resumes without loss.
// A push to a full queue is dropped with status full; a pop or show of an
// empty queue answers status empty. Reset empties the queue and drops any
// pending response; memory contents are not cleared and need no sweep.
`default_nettype none
`include "assert_macros.svh"

module circular_deque_engine (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdq_req_if.sink    i_req,
    cdq_rsp_if.source  o_rsp
);

    cdq_pkg::t_dp_cmd   w_cmd;
    cdq_pkg::t_dp_stat  w_stat;
    logic               w_req_ready;
    logic               w_rsp_valid;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    cdq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_command    (i_req.command),
        .i_value      (i_req.value),
        .o_stat       (w_stat),
        .o_status     (o_rsp.status),
        .o_item_value (o_rsp.item_value),
        .o_last       (o_rsp.last)
    );

    assign i_req.ready = w_req_ready;
    assign o_rsp.valid = w_rsp_valid;

    `CDQ_ASSERT(a_no_rsp_overwrite, i_clk, i_rst_n, !w_cmd.out_load || !o_rsp.valid || o_rsp.ready)
    `CDQ_ASSERT(a_no_push_when_full, i_clk, i_rst_n, !(w_cmd.push_front || w_cmd.push_back) || !w_stat.full)
    `CDQ_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, !(w_cmd.pop_front || w_cmd.pop_back) || !w_stat.empty)
    `CDQ_ASSERT_NEXT(a_one_request_at_a_time, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)

endmodule

`default_nettype wire

@@ bench/circular_deque_engine_checker.sv @@
module circular_deque_engine_checker
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cdq_req_if   i_req,
    cdq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_due_count
);

    typedef struct {
        t_status status;
        t_value  item_value;
        logic    last;
    } t_deque_rsp;

    t_value     ring_mem [DEPTH];
    t_idx       ring_front;
    t_cnt       ring_count;
    t_deque_rsp due_rsp [$];
    int         fails   = 0;
    int         due_now = 0;

    assign o_fail_count = fails;
    assign o_due_count  = due_now;

    function automatic t_idx ring_pos(input int offset);
        return t_idx'((int'(ring_front) + offset) % DEPTH);
    endfunction

    function automatic void deque_apply(input logic [CMD_W-1:0] cmd, input t_value val);
        t_deque_rsp r;
        r.status     = RS_OK;
        r.item_value = '0;
        r.last       = 1'b1;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (ring_count == DEPTH) begin
                    r.status = RS_FULL;
                end else begin
                    if (cmd == CMD_PUSH_FRONT) begin
                        ring_front           = ring_pos(DEPTH - 1);
                        ring_mem[ring_front] = val;
                    end else begin
                        ring_mem[ring_pos(ring_count)] = val;
                    end
                    ring_count = ring_count + 1'b1;
                end
                due_rsp.push_back(r);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (ring_count == 0) begin
                    r.status = RS_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        r.item_value = ring_mem[ring_front];
                        ring_front   = ring_pos(1);
                    end else begin
                        r.item_value = ring_mem[ring_pos(ring_count - 1)];
                    end
                    ring_count = ring_count - 1'b1;
                end
                due_rsp.push_back(r);
            end
            CMD_SHOW: begin
                if (ring_count == 0) begin
                    r.status = RS_EMPTY;
                    due_rsp.push_back(r);
                end else begin
                    for (int k = 0; k < ring_count; k++) begin
                        r.item_value = ring_mem[ring_pos(k)];
                        r.last       = (k == ring_count - 1);
                        due_rsp.push_back(r);
                    end
                end
            end
            CMD_CLEAR: begin
                ring_count = '0;
                ring_front = '0;
                due_rsp.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string field, input longint want,
                                            input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fails++;
    endfunction

    always @(posedge i_clk) begin
        t_deque_rsp want;
        if (!i_rst_n) begin
            ring_front = '0;
            ring_count = '0;
            due_rsp.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                deque_apply(i_req.command, i_req.value);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_rsp.size() == 0) begin
                    $display("%0t: response with none due, expected nothing, actual %0d/%0d/%0d",
                             $time, i_rsp.status, i_rsp.item_value, i_rsp.last);
                    fails++;
                end else begin
                    want = due_rsp.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch("status", want.status, i_rsp.status);
                    end
                    if (i_rsp.item_value !== want.item_value) begin
                        report_mismatch("item_value", want.item_value, i_rsp.item_value);
                    end
                    if (i_rsp.last !== want.last) begin
                        report_mismatch("last", want.last, i_rsp.last);
                    end
                end
            end
        end
        due_now = due_rsp.size();
    end

endmodule

@@ bench/circular_deque_engine_test.sv @@
module circular_deque_engine_test;
    import cdq_pkg::*;

    localparam int RUN_LIMIT     = 1000000;
    localparam int LONG_HOLD     = 300;
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASE_ITEMS   = 64;
    localparam int MODE_SPAN     = 30;
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cdq_req_if req_ch ();
    cdq_rsp_if rsp_ch ();

    int fail_count;
    int due_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int stall_ticket  = 0;

    circular_deque_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    circular_deque_engine_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** circular_deque_engine: FAILED **");
            $finish;
        end
    end

    // drive response ready; sample controls at the rising edge, drive at the falling edge
    initial begin
        int stall_seen;
        int hold_left;
        int pct;
        stall_seen   = 0;
        hold_left    = 0;
        pct          = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_ticket != stall_seen) begin
                stall_seen = stall_ticket;
                hold_left  = LONG_HOLD;
            end
            pct = rcv_idle_pct;
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= pct);
            end
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input t_value val);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.command = cmd;
        req_ch.value   = val;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_all_answered();
        req_ch.valid = 1'b0;
        while (due_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return t_value'($urandom);
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int mode);
        int r;
        int push_pct;
        r        = $urandom_range(99);
        push_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 15 : 47;
        if (r < push_pct) begin
            return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else if (r < 93) begin
            return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end else if (r < 99) begin
            return CMD_SHOW;
        end
        return CMD_CLEAR;
    endfunction

    task automatic random_phase(input int count);
        int mode;
        mode = MODE_MIXED;
        for (int i = 0; i < count; i++) begin
            if (i % MODE_SPAN == 0) begin
                mode = $urandom_range(MODE_MIXED);
            end
            // slip in an unused code now and then
            if ($urandom_range(99) < 3) begin
                send_request($urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B, pick_value());
            end
            send_request(pick_command(mode), pick_value());
        end
    endtask

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_CLEAR;
        req_ch.value   = '0;
        send_idle_pct  = 19;
        rcv_idle_pct   = 86;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(CMD_POP_FRONT, 32'sh1234_5678);
        send_request(CMD_POP_BACK, '1);
        send_request(CMD_SHOW, '0);
        send_request(CMD_CLEAR, '0);
        send_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_request(CMD_PUSH_BACK, 32'sh8000_0000);
        send_request(CMD_PUSH_FRONT, '0);
        send_request(CMD_PUSH_BACK, '1);
        send_request(CMD_SHOW, '0);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_SHOW, '0);
        send_request(CMD_SPARE_A, 32'sh5555_5555);
        send_request(CMD_SPARE_B, 32'shaaaa_aaaa);
        send_request(CMD_PUSH_BACK, 32'sh5555_5555);
        send_request(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
        send_request(CMD_CLEAR, '0);
        send_request(CMD_SHOW, '0);
        send_request(CMD_POP_BACK, '0);

        // hold the receiver and keep pushing past full, so the last pushes answer full
        stall_ticket++;
        repeat (DEPTH + 4) begin
            send_request($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end
        send_request(CMD_SHOW, '0);
        wait_all_answered();
        repeat (DEPTH + 2) begin
            send_request($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, '0);
        end

        random_phase(PHASE_ITEMS);
        send_idle_pct = 86;
        rcv_idle_pct  = 19;
        random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        random_phase(PHASE_ITEMS);

        wait_all_answered();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("** circular_deque_engine: PASSED **");
        end else begin
            $display("** circular_deque_engine: FAILED **");
        end
        $finish;
    end

endmodule
